@@ hdl/smc_pkg.sv @@
// Shared types and constants for the single-cycle MIPS subset core.
// No dependencies; used by smc_exec, the top level, the checker and the bench.
package smc_pkg;

	localparam int unsigned MEM_WORDS_DEF = 1024;

	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_BEQ   = 6'h04;
	localparam logic [5:0] OP_LW    = 6'h23;
	localparam logic [5:0] OP_SW    = 6'h2b;

	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_SLT  = 6'h2a;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_OP    = 2'd1,
		ST_BAD_FUNCT = 2'd2,
		ST_BAD_ADDR  = 2'd3
	} status_t;

	// Decode/execute result handed from the execute stage to the result stage.
	typedef struct packed {
		logic [31:0] next_pc;
		logic        reg_wr;
		logic [4:0]  dest_idx;
		logic [31:0] alu;
		logic        load;
		logic        store;
		logic [31:0] store_data;
		logic        taken;
		status_t     status;
	} exec_res_t;

endpackage

@@ hdl/smc_regfile.sv @@
// 32 x 32 register file: one write port, two registered read ports.
// Per-entry valid bits give the zero reset value. Depends on nothing.
module smc_regfile (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rd_en,
	input  logic [4:0]  rs_addr,
	input  logic [4:0]  rt_addr,
	input  logic        we,
	input  logic [4:0]  waddr,
	input  logic [31:0] wdata,
	output logic [31:0] rs_data,
	output logic [31:0] rt_data
);

	logic [31:0] rf_mem [32];
	logic [31:0] vld_q;
	logic [31:0] rs_data_q;
	logic [31:0] rt_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			rf_mem[waddr] <= wdata;
		end
	end

	// write-through so a read in the same cycle as a write sees the new word
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (we && waddr == rs_addr)
				rs_data_q <= wdata;
			else
				rs_data_q <= vld_q[rs_addr] ? rf_mem[rs_addr] : '0;
			if (we && waddr == rt_addr)
				rt_data_q <= wdata;
			else
				rt_data_q <= vld_q[rt_addr] ? rf_mem[rt_addr] : '0;
		end
	end

	assign rs_data = rs_data_q;
	assign rt_data = rt_data_q;

endmodule

@@ hdl/smc_dmem.sv @@
// Word data memory with registered read and a zeroing sweep after reset.
// Depends on nothing; MEM_WORDS is handed down from the top level.
module smc_dmem #(
	parameter int unsigned MEM_WORDS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	output logic                         busy,
	input  logic                         rd_en,
	input  logic                         we,
	input  logic [$clog2(MEM_WORDS)-1:0] addr,
	input  logic [31:0]                  wdata,
	output logic [31:0]                  rdata
);

	localparam int unsigned AW = $clog2(MEM_WORDS);

	logic [31:0]   mem [MEM_WORDS];
	logic [31:0]   rdata_q;
	logic          clr_busy_q;
	logic [AW-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == AW'(MEM_WORDS - 1))
				clr_busy_q <= 1'b0;
			else
				clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q)
			mem[clr_idx_q] <= '0;
		else if (we)
			mem[addr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign busy  = clr_busy_q;
	assign rdata = rdata_q;

endmodule

@@ hdl/smc_exec.sv @@
// Decode and execute: ALU, address generation and range check, branch target.
// Uses smc_pkg (opcodes, functs, status codes, exec_res_t).
module smc_exec #(
	parameter int unsigned MEM_WORDS = 1024
) (
	input  logic [31:0]                  insn,
	input  logic [31:0]                  rs_val,
	input  logic [31:0]                  rt_val,
	input  logic [31:0]                  pc,
	output smc_pkg::exec_res_t           res,
	output logic [$clog2(MEM_WORDS)-1:0] mem_idx
);

	localparam int unsigned AW = $clog2(MEM_WORDS);
	localparam logic [32:0] ByteLimit = 33'(MEM_WORDS) << 2;

	logic [5:0]  opcode;
	logic [5:0]  funct;
	logic [4:0]  rt;
	logic [4:0]  rd;
	logic [31:0] simm;
	logic [31:0] addr;
	logic [31:0] pc4;
	logic        in_range;

	assign opcode   = insn[31:26];
	assign rt       = insn[20:16];
	assign rd       = insn[15:11];
	assign funct    = insn[5:0];
	assign simm     = {{16{insn[15]}}, insn[15:0]};
	assign addr     = rs_val + simm;
	assign pc4      = pc + 32'd4;
	assign in_range = {1'b0, addr} < ByteLimit;
	assign mem_idx  = addr[AW+1:2];

	always_comb begin
		logic        ok;
		logic [31:0] r;
		res        = '0;
		res.next_pc = pc4;
		res.status = smc_pkg::ST_OK;
		ok         = 1'b1;
		r          = '0;
		unique case (opcode) inside
			smc_pkg::OP_RTYPE: begin
				unique case (funct) inside
					smc_pkg::FN_ADD, smc_pkg::FN_ADDU: r = rs_val + rt_val;
					smc_pkg::FN_SUB, smc_pkg::FN_SUBU: r = rs_val - rt_val;
					smc_pkg::FN_AND: r = rs_val & rt_val;
					smc_pkg::FN_OR:  r = rs_val | rt_val;
					smc_pkg::FN_NOR: r = ~(rs_val | rt_val);
					smc_pkg::FN_SLT: r = {31'b0, $signed(rs_val) < $signed(rt_val)};
					default:         ok = 1'b0;
				endcase
				if (ok) begin
					res.alu = r;
					if (rd != 5'd0) begin
						res.reg_wr   = 1'b1;
						res.dest_idx = rd;
					end
				end else begin
					res.status = smc_pkg::ST_BAD_FUNCT;
				end
			end
			smc_pkg::OP_LW, smc_pkg::OP_SW: begin
				res.alu = addr;
				if (!in_range) begin
					res.status = smc_pkg::ST_BAD_ADDR;
				end else if (opcode == smc_pkg::OP_LW) begin
					if (rt != 5'd0) begin
						res.reg_wr   = 1'b1;
						res.dest_idx = rt;
						res.load     = 1'b1;
					end
				end else begin
					res.store      = 1'b1;
					res.store_data = rt_val;
				end
			end
			smc_pkg::OP_BEQ: begin
				res.alu = rs_val - rt_val;
				if (rs_val == rt_val) begin
					res.taken   = 1'b1;
					res.next_pc = pc4 + {simm[29:0], 2'b00};
				end
			end
			default: res.status = smc_pkg::ST_BAD_OP;
		endcase
	end

endmodule

@@ hdl/single_cycle_mips_subset_core.sv @@
// Top level of the MIPS subset core: input stage, result stage, PC, forwarding.
// Uses smc_pkg, smc_regfile, smc_dmem and smc_exec.
//
// channel   dir  tdata fields (low bit first)
// s_axis    in   instruction[31:0]
// m_axis    out  next_pc, reg_written, dest_index, dest_value, alu_value,
//                stored, store_data, branch_taken, status, 6 zero bits
//
// One word accepted per cycle unless m_axis stalls or the reset sweep runs; a
// result is registered in the result stage when its word leaves s1.
// Register reads happen at accept, memory reads at the s1->s2 step; the
// result stage forwards its register write back into s1.
// After reset a zeroing sweep clears every word of the data memory,
// with s_axis_tready low throughout.
// A stalled m_axis holds the result stage, then s1, then s_axis_tready.
module single_cycle_mips_subset_core #(
	parameter int unsigned MEM_WORDS = smc_pkg::MEM_WORDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,   // instruction[31:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [143:0] m_axis_tdata    // next_pc[31:0], reg_written[32],
	                                     // dest_index[37:33], dest_value[69:38],
	                                     // alu_value[101:70], stored[102],
	                                     // store_data[134:103], branch_taken[135],
	                                     // status[137:136], zero[143:138]
);

	localparam int unsigned AW = $clog2(MEM_WORDS);

	logic               in_acc;
	logic               s1_adv;
	logic               clr_busy;
	logic               s1_vld_q;
	logic [31:0]        insn_s1;
	logic               s2_vld_q;
	smc_pkg::exec_res_t res_s2;
	smc_pkg::exec_res_t res;
	logic [31:0]        pc_q;
	logic [31:0]        rs_raw;
	logic [31:0]        rt_raw;
	logic [31:0]        rs_val;
	logic [31:0]        rt_val;
	logic [AW-1:0]      mem_idx;
	logic [31:0]        mem_rdata;
	logic               wb_en;
	logic [31:0]        wb_data;
	logic [31:0]        dest_value;

	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign s1_adv        = s1_vld_q & (~s2_vld_q | m_axis_tready);
	assign s_axis_tready = ~clr_busy & (~s1_vld_q | s1_adv);

	assign wb_en   = s2_vld_q & res_s2.reg_wr;
	assign wb_data = res_s2.load ? mem_rdata : res_s2.alu;

	smc_regfile u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rs_addr (s_axis_tdata[25:21]),
		.rt_addr (s_axis_tdata[20:16]),
		.we      (wb_en),
		.waddr   (res_s2.dest_idx),
		.wdata   (wb_data),
		.rs_data (rs_raw),
		.rt_data (rt_raw)
	);

	// the word in s2 may not have reached the register file yet
	assign rs_val = (wb_en && res_s2.dest_idx == insn_s1[25:21]) ? wb_data : rs_raw;
	assign rt_val = (wb_en && res_s2.dest_idx == insn_s1[20:16]) ? wb_data : rt_raw;

	smc_exec #(
		.MEM_WORDS (MEM_WORDS)
	) u_exec (
		.insn    (insn_s1),
		.rs_val  (rs_val),
		.rt_val  (rt_val),
		.pc      (pc_q),
		.res     (res),
		.mem_idx (mem_idx)
	);

	smc_dmem #(
		.MEM_WORDS (MEM_WORDS)
	) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (clr_busy),
		.rd_en  (s1_adv),
		.we     (s1_adv & res.store),
		.addr   (mem_idx),
		.wdata  (res.store_data),
		.rdata  (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			s2_vld_q <= 1'b0;
			pc_q     <= '0;
		end else begin
			if (in_acc)
				s1_vld_q <= 1'b1;
			else if (s1_adv)
				s1_vld_q <= 1'b0;
			if (s1_adv)
				s2_vld_q <= 1'b1;
			else if (m_axis_tready)
				s2_vld_q <= 1'b0;
			if (s1_adv)
				pc_q <= res.next_pc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			insn_s1 <= s_axis_tdata;
		if (s1_adv)
			res_s2 <= res;
	end

	assign dest_value    = res_s2.reg_wr ? wb_data : '0;
	assign m_axis_tvalid = s2_vld_q;
	assign m_axis_tdata  = {6'b0, res_s2.status, res_s2.taken, res_s2.store_data,
		res_s2.store, res_s2.alu, dest_value, res_s2.dest_idx, res_s2.reg_wr,
		res_s2.next_pc};

endmodule

@@ hdl/smc_checker.sv @@
// Port-level checks for single_cycle_mips_subset_core, attached by bind.
// Uses smc_pkg for the status codes.
module smc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [143:0] m_axis_tdata
);

	logic        reg_written;
	logic [4:0]  dest_index;
	logic [31:0] dest_value;
	logic [31:0] alu_value;
	logic        stored;
	logic        branch_taken;
	logic [1:0]  status;

	assign reg_written  = m_axis_tdata[32];
	assign dest_index   = m_axis_tdata[37:33];
	assign dest_value   = m_axis_tdata[69:38];
	assign alu_value    = m_axis_tdata[101:70];
	assign stored       = m_axis_tdata[102];
	assign branch_taken = m_axis_tdata[135];
	assign status       = m_axis_tdata[137:136];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	a_err_no_effect: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status != smc_pkg::ST_OK |-> !reg_written && !stored && !branch_taken)
		else $error("error status with a side effect");

	a_dest: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (reg_written == (dest_index != 5'd0))
			&& (reg_written || dest_value == 32'd0))
		else $error("destination fields inconsistent");

	a_taken: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && branch_taken |-> alu_value == 32'd0 && !reg_written && !stored)
		else $error("taken branch with nonzero compare or a write");

	// an accepted word must be followed by a valid word on m_axis
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
		else $error("accepted word produced no result");

endmodule

bind single_cycle_mips_subset_core smc_checker u_smc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

@@ bench/tb_single_cycle_mips_subset_core.sv @@
// Self-checking bench for single_cycle_mips_subset_core: directed and random instruction words
// go in, and a bench-side executor of the register file, data memory and PC checks every result.
// Depends on smc_pkg and the core RTL.
module tb_single_cycle_mips_subset_core;

	localparam int unsigned MEM_WORDS = smc_pkg::MEM_WORDS_DEF;
	localparam logic [5:0] OP_J   = 6'h02;
	localparam logic [5:0] OP_ALL = 6'h3f;
	localparam logic [5:0] FN_SLL = 6'h00;
	localparam logic [5:0] FN_XOR = 6'h26;
	localparam logic [5:0] FN_BAD = 6'h3f;

	// m_axis_tdata layout, highest field first
	typedef struct packed {
		logic [5:0]       pad;
		smc_pkg::status_t status;
		logic             taken;
		logic [31:0]      store_data;
		logic             stored;
		logic [31:0]      alu_value;
		logic [31:0]      dest_value;
		logic [4:0]       dest_index;
		logic             reg_written;
		logic [31:0]      next_pc;
	} retire_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [31:0]  s_axis_tdata = '0;   // instruction[31:0]
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [143:0] m_axis_tdata;        // next_pc, reg_written, dest_index, dest_value,
	                                   // alu_value, stored, store_data, branch_taken, status

	logic [31:0] pc = '0;
	logic [31:0] gpr [32] = '{default: '0};
	logic [31:0] dmem [MEM_WORDS] = '{default: '0};

	logic [31:0] insn_q [$];
	retire_t     retire_q [$];
	int          n_issued = 0;
	int          n_accepted = 0;
	int          n_errors = 0;
	bit          in_fire = 1'b0;
	bit          no_idle = 1'b0;

	single_cycle_mips_subset_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [31:0] rtype(logic [5:0] funct, logic [4:0] rs, logic [4:0] rt,
			logic [4:0] rd, logic [4:0] shamt);
		return {smc_pkg::OP_RTYPE, rs, rt, rd, shamt, funct};
	endfunction

	function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [4:0] pick_reg();
		return ($urandom_range(99) < 70) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
	endfunction

	function automatic logic [31:0] random_insn();
		logic [5:0]  fn_list [8];
		logic [5:0]  f;
		logic [4:0]  rs;
		logic [15:0] imm;
		int          k;
		int          j;
		fn_list = '{smc_pkg::FN_ADD, smc_pkg::FN_ADDU, smc_pkg::FN_SUB, smc_pkg::FN_SUBU,
			smc_pkg::FN_AND, smc_pkg::FN_OR, smc_pkg::FN_NOR, smc_pkg::FN_SLT};
		k = $urandom_range(99);
		if (k < 45)
			return rtype(fn_list[$urandom_range(7)], pick_reg(), pick_reg(), pick_reg(),
				5'($urandom_range(31)));
		if (k < 75) begin
			j = $urandom_range(9);
			rs = 5'd0;
			if (j < 4)
				imm = 16'($urandom_range(255));
			else if (j < 7)
				imm = 16'($urandom_range(MEM_WORDS * 4 - 1));
			else if (j == 7)
				imm = 16'($urandom_range(MEM_WORDS * 4 + 7, MEM_WORDS * 4 - 8));
			else begin
				rs = pick_reg();
				imm = 16'($urandom_range(65535));
			end
			return itype((k < 60) ? smc_pkg::OP_LW : smc_pkg::OP_SW, rs, pick_reg(), imm);
		end
		if (k < 85) begin
			rs = pick_reg();
			return itype(smc_pkg::OP_BEQ, rs, $urandom_range(1) ? rs : pick_reg(),
				16'($urandom_range(65535)));
		end
		if (k < 92) begin
			do
				f = 6'($urandom_range(63));
			while (f inside {smc_pkg::FN_ADD, smc_pkg::FN_ADDU, smc_pkg::FN_SUB,
				smc_pkg::FN_SUBU, smc_pkg::FN_AND, smc_pkg::FN_OR, smc_pkg::FN_NOR,
				smc_pkg::FN_SLT});
			return rtype(f, pick_reg(), pick_reg(), pick_reg(), 5'($urandom_range(31)));
		end
		return $urandom();
	endfunction

	// Executes one instruction on the bench copy of the core state.
	function automatic void execute_insn(logic [31:0] insn);
		logic [5:0]  opcode;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [31:0] simm;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] addr;
		logic        ok;
		retire_t     r;
		opcode = insn[31:26];
		rs = insn[25:21];
		rt = insn[20:16];
		rd = insn[15:11];
		simm = {{16{insn[15]}}, insn[15:0]};
		a = gpr[rs];
		b = gpr[rt];
		r = '0;
		r.status = smc_pkg::ST_OK;
		r.next_pc = pc + 32'd4;
		if (opcode == smc_pkg::OP_RTYPE) begin
			ok = 1'b1;
			case (insn[5:0])
				smc_pkg::FN_ADD, smc_pkg::FN_ADDU: r.alu_value = a + b;
				smc_pkg::FN_SUB, smc_pkg::FN_SUBU: r.alu_value = a - b;
				smc_pkg::FN_AND: r.alu_value = a & b;
				smc_pkg::FN_OR: r.alu_value = a | b;
				smc_pkg::FN_NOR: r.alu_value = ~(a | b);
				smc_pkg::FN_SLT: r.alu_value = {31'd0, $signed(a) < $signed(b)};
				default: ok = 1'b0;
			endcase
			if (!ok) begin
				r.status = smc_pkg::ST_BAD_FUNCT;
			end else if (rd != 5'd0) begin
				r.reg_written = 1'b1;
				r.dest_index = rd;
				r.dest_value = r.alu_value;
			end
		end else if (opcode == smc_pkg::OP_LW || opcode == smc_pkg::OP_SW) begin
			addr = a + simm;
			r.alu_value = addr;
			if (addr >= MEM_WORDS * 4) begin
				r.status = smc_pkg::ST_BAD_ADDR;
			end else if (opcode == smc_pkg::OP_LW) begin
				if (rt != 5'd0) begin
					r.reg_written = 1'b1;
					r.dest_index = rt;
					r.dest_value = dmem[addr >> 2];
				end
			end else begin
				dmem[addr >> 2] = b;
				r.stored = 1'b1;
				r.store_data = b;
			end
		end else if (opcode == smc_pkg::OP_BEQ) begin
			r.alu_value = a - b;
			if (a == b) begin
				r.taken = 1'b1;
				r.next_pc = pc + 32'd4 + (simm << 2);
			end
		end else begin
			r.status = smc_pkg::ST_BAD_OP;
		end
		if (r.reg_written)
			gpr[r.dest_index] = r.dest_value;
		pc = r.next_pc;
		retire_q.push_back(r);
	endfunction

	task automatic cmp(string name, logic [31:0] exp, logic [31:0] act);
		if (exp !== act) begin
			$error("%s: expected %h, got %h", name, exp, act);
			n_errors++;
		end
	endtask

	// monitor: predict on input words, check output words
	always @(posedge clk) begin
		retire_t got;
		retire_t exp;
		in_fire = arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = retire_t'(m_axis_tdata);
			if (retire_q.size() == 0) begin
				$error("unexpected output word %h", m_axis_tdata);
				n_errors++;
			end else begin
				exp = retire_q.pop_front();
				cmp("next_pc", exp.next_pc, got.next_pc);
				cmp("reg_written", exp.reg_written, got.reg_written);
				cmp("dest_index", exp.dest_index, got.dest_index);
				cmp("dest_value", exp.dest_value, got.dest_value);
				cmp("alu_value", exp.alu_value, got.alu_value);
				cmp("stored", exp.stored, got.stored);
				cmp("store_data", exp.store_data, got.store_data);
				cmp("branch_taken", exp.taken, got.taken);
				cmp("status", exp.status, got.status);
				cmp("pad", exp.pad, got.pad);
			end
		end
		if (in_fire) begin
			execute_insn(s_axis_tdata);
			n_accepted++;
		end
	end

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_fire) begin
			if (insn_q.size() > 0 && (no_idle || $urandom_range(99) >= 17)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= insn_q.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// sink
	always @(negedge clk) begin
		m_axis_tready <= no_idle || ($urandom_range(99) >= 17);
	end

	task automatic issue(logic [31:0] insn);
		insn_q.push_back(insn);
		n_issued++;
	endtask

	task automatic drain();
		while (n_accepted != n_issued || retire_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		issue(rtype(smc_pkg::FN_NOR, 5'd0, 5'd0, 5'd1, 5'd0));      // r1 = -1
		issue(rtype(smc_pkg::FN_SUB, 5'd0, 5'd1, 5'd2, 5'd0));      // r2 = 1
		issue(rtype(smc_pkg::FN_ADD, 5'd1, 5'd1, 5'd3, 5'd31));     // shamt ignored
		issue(rtype(smc_pkg::FN_ADDU, 5'd2, 5'd2, 5'd4, 5'd0));
		issue(rtype(smc_pkg::FN_SUBU, 5'd0, 5'd2, 5'd5, 5'd0));
		issue(rtype(smc_pkg::FN_AND, 5'd1, 5'd4, 5'd6, 5'd0));
		issue(rtype(smc_pkg::FN_OR, 5'd2, 5'd4, 5'd7, 5'd0));
		issue(rtype(smc_pkg::FN_SLT, 5'd1, 5'd2, 5'd8, 5'd0));      // signed: -1 < 1
		issue(rtype(smc_pkg::FN_SLT, 5'd2, 5'd1, 5'd9, 5'd0));
		issue(rtype(smc_pkg::FN_ADD, 5'd1, 5'd1, 5'd0, 5'd0));      // rd zero
		issue(itype(smc_pkg::OP_SW, 5'd0, 5'd7, 16'h0000));
		issue(itype(smc_pkg::OP_SW, 5'd0, 5'd1, 16'(MEM_WORDS * 4 - 4)));
		issue(itype(smc_pkg::OP_LW, 5'd0, 5'd31, 16'(MEM_WORDS * 4 - 4)));
		issue(itype(smc_pkg::OP_LW, 5'd0, 5'd10, 16'h7fff));        // out of range
		issue(itype(smc_pkg::OP_LW, 5'd0, 5'd10, 16'h8000));        // negative address
		issue(itype(smc_pkg::OP_LW, 5'd7, 5'd11, 16'h0001));        // r7 (3) plus 1: aligned address 4
		issue(itype(smc_pkg::OP_LW, 5'd0, 5'd0, 16'h0000));         // rt zero
		issue(itype(smc_pkg::OP_SW, 5'd0, 5'd2, 16'(MEM_WORDS * 4))); // first address past the end
		issue(itype(smc_pkg::OP_BEQ, 5'd1, 5'd5, 16'hffff));        // taken backward
		issue(itype(smc_pkg::OP_BEQ, 5'd1, 5'd2, 16'h7fff));        // not taken
		issue(itype(OP_J, 5'd3, 5'd4, 16'h1234));
		issue({OP_ALL, 26'h3ffffff});
		issue(rtype(FN_BAD, 5'd31, 5'd31, 5'd31, 5'd31));
		issue(rtype(FN_XOR, 5'd1, 5'd2, 5'd12, 5'd0));
		issue({smc_pkg::OP_RTYPE, 20'd0, FN_SLL});
		issue(itype(smc_pkg::OP_BEQ, 5'd0, 5'd0, 16'h8000));        // taken, most negative offset
		drain();

		repeat (650) issue(random_insn());
		drain();

		no_idle = 1'b1;
		repeat (250) issue(random_insn());
		while (n_accepted != n_issued)
			@(negedge clk);
		no_idle = 1'b0;
		repeat (500) issue(random_insn());
		drain();

		repeat (8) @(posedge clk);
		if (n_errors == 0)
			$display("single_cycle_mips_subset_core verification clean");
		else
			$display("single_cycle_mips_subset_core verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("single_cycle_mips_subset_core verification failed");
		$finish;
	end

endmodule
